// ----- sv/fbpa_pkg.sv -----
// Shared types, field widths and codes of the fixed block pool allocator.
package fbpa_pkg;

    // Field widths of the request, response and configuration registers.
    localparam int unsigned ADDR_BITS   = 32;
    localparam int unsigned BYTES_W     = 17;
    localparam int unsigned POOL_W      = 9;
    localparam int unsigned IDX_OUT_W   = 8;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Default pool capacity of the block memory.
    localparam int unsigned DEF_MAX_BLOCKS = 256;

    // Register values after reset.
    localparam logic [BYTES_W-1:0]   BLOCK_BYTES_RST = BYTES_W'(64);
    localparam logic [POOL_W-1:0]    POOL_BLOCKS_RST = POOL_W'(256);
    localparam logic [ADDR_BITS-1:0] POOL_BASE_RST   = '0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = CFG_IDX_W'(2);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and launch the memory read
        logic commit;   // update the list and load the response register
    } t_ctrl_cmd;

endpackage

// ----- sv/fbpa_ifs.sv -----
// Valid/ready channel interfaces for allocator requests and responses.
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [BYTES_W-1:0]   request_bytes;
    logic [IDX_OUT_W-1:0] freed_index;

    modport source (output valid, output req_type, output request_bytes,
                    output freed_index, input ready);
    modport sink   (input valid, input req_type, input request_bytes,
                    input freed_index, output ready);
endinterface

interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] given_index;
    logic [ADDR_BITS-1:0] given_address;
    logic [POOL_W-1:0]    blocks_free;

    modport source (output valid, output status, output given_index,
                    output given_address, output blocks_free, input ready);
    modport sink   (input valid, input status, input given_index,
                    input given_address, input blocks_free, output ready);
endinterface

// ----- sv/fbpa_ctrl.sv -----
// Request sequencing state machine and response valid flag of the allocator.
module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output fbpa_pkg::t_ctrl_cmd o_cmd
);
    import fbpa_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        slot_free;

    // The response register can take a new result when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/fbpa_datapath.sv -----
// Free list memory, list registers, configuration and response registers.
module fbpa_datapath #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbpa_pkg::t_ctrl_cmd                 i_cmd,
    input  logic                                i_req_type,
    input  logic [fbpa_pkg::BYTES_W-1:0]        i_request_bytes,
    input  logic [fbpa_pkg::IDX_OUT_W-1:0]      i_freed_index,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [fbpa_pkg::STATUS_W-1:0]       o_status,
    output logic [fbpa_pkg::IDX_OUT_W-1:0]      o_given_index,
    output logic [fbpa_pkg::ADDR_BITS-1:0]      o_given_address,
    output logic [fbpa_pkg::POOL_W-1:0]         o_blocks_free
);
    import fbpa_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned MEM_W  = IDX_W + 1;
    localparam int unsigned PROD_W = IDX_W + BYTES_W;

    // Clamp a pool size write into the range one to MAX_BLOCKS.
    function automatic logic [CNT_W-1:0] pool_clamp(input logic [POOL_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > 32'(MAX_BLOCKS)) begin
            r = CNT_W'(MAX_BLOCKS);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [BYTES_W-1:0]   r_block_bytes, n_block_bytes;
    logic [ADDR_BITS-1:0] r_pool_base,   n_pool_base;
    logic [CNT_W-1:0]     r_pool_n,      n_pool_n;

    // Free list state. Blocks below r_fresh have never left the pool since the
    // last rebuild; they form the tail of the list with implicit links i-1.
    logic [IDX_W-1:0]     r_head,     n_head;
    logic [CNT_W-1:0]     r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]     r_fresh,    n_fresh;

    // Captured request.
    t_req_type            r_req_type;
    logic [BYTES_W-1:0]   r_req_bytes;
    logic [IDX_OUT_W-1:0] r_req_idx;

    // Link memory: in-use flag above the next link of each block.
    logic [MEM_W-1:0]     r_mem [MAX_BLOCKS];
    logic [MEM_W-1:0]     r_rd_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;

    // Response registers.
    t_status              r_out_status, n_out_status;
    logic [IDX_OUT_W-1:0] r_out_index,  n_out_index;
    logic [ADDR_BITS-1:0] r_out_addr,   n_out_addr;
    logic [POOL_W-1:0]    r_out_free;

    logic [PROD_W-1:0]    prod;
    logic [IDX_W-1:0]     free_idx;
    logic                 head_fresh;
    logic                 idx_fresh;
    logic                 in_use;
    logic                 rebuild;
    logic [CNT_W-1:0]     rb_n;

    assign free_idx   = IDX_W'(r_req_idx);
    assign head_fresh = CNT_W'(r_head) < r_fresh;
    assign idx_fresh  = CNT_W'(free_idx) < r_fresh;
    assign in_use     = !idx_fresh && r_rd_data[IDX_W];
    assign prod       = {{BYTES_W{1'b0}}, r_head} * {{IDX_W{1'b0}}, r_block_bytes};

    assign rd_addr = (t_req_type'(i_req_type) == REQ_ALLOC) ? r_head
                                                            : IDX_W'(i_freed_index);

    always_comb begin
        n_block_bytes = r_block_bytes;
        n_pool_base   = r_pool_base;
        n_pool_n      = r_pool_n;
        n_head        = r_head;
        n_free_cnt    = r_free_cnt;
        n_fresh       = r_fresh;
        n_out_status  = STAT_OK;
        n_out_index   = '0;
        n_out_addr    = '0;
        mem_we        = 1'b0;
        mem_waddr     = r_head;
        mem_wdata     = '0;
        rebuild       = 1'b0;
        rb_n          = r_pool_n;

        if (i_cmd.commit) begin
            if (r_req_type == REQ_ALLOC) begin
                if (r_req_bytes > r_block_bytes) begin
                    n_out_status = STAT_TOO_LARGE;
                end else if (r_free_cnt == '0) begin
                    n_out_status = STAT_EMPTY;
                end else begin
                    n_out_index = IDX_OUT_W'(r_head);
                    n_out_addr  = r_pool_base + ADDR_BITS'(prod);
                    n_free_cnt  = r_free_cnt - CNT_W'(1);
                    mem_we      = 1'b1;
                    mem_waddr   = r_head;
                    mem_wdata   = {1'b1, {IDX_W{1'b0}}};
                    if (head_fresh) begin
                        n_fresh = r_fresh - CNT_W'(1);
                        n_head  = (r_head == '0) ? '0 : r_head - IDX_W'(1);
                    end else begin
                        n_head = r_rd_data[IDX_W-1:0];
                    end
                end
            end else begin
                if (32'(r_req_idx) >= 32'(r_pool_n) || !in_use) begin
                    n_out_status = STAT_BAD_INDEX;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = free_idx;
                    mem_wdata  = {1'b0, r_head};
                    n_head     = free_idx;
                    n_free_cnt = r_free_cnt + CNT_W'(1);
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_BYTES: begin
                    n_block_bytes = i_cfg_data[BYTES_W-1:0];
                    rebuild       = 1'b1;
                end
                CFG_POOL_BLOCKS: begin
                    rb_n    = pool_clamp(i_cfg_data[POOL_W-1:0]);
                    rebuild = 1'b1;
                end
                CFG_POOL_BASE: begin
                    n_pool_base = i_cfg_data[ADDR_BITS-1:0];
                    rebuild     = 1'b1;
                end
                default: begin
                    rebuild = 1'b0;
                end
            endcase
        end

        if (rebuild) begin
            n_pool_n   = rb_n;
            n_head     = IDX_W'(rb_n - CNT_W'(1));
            n_free_cnt = rb_n;
            n_fresh    = rb_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_pool_base   <= POOL_BASE_RST;
            r_pool_n      <= pool_clamp(POOL_BLOCKS_RST);
            r_head        <= IDX_W'(pool_clamp(POOL_BLOCKS_RST) - CNT_W'(1));
            r_free_cnt    <= pool_clamp(POOL_BLOCKS_RST);
            r_fresh       <= pool_clamp(POOL_BLOCKS_RST);
        end else begin
            r_block_bytes <= n_block_bytes;
            r_pool_base   <= n_pool_base;
            r_pool_n      <= n_pool_n;
            r_head        <= n_head;
            r_free_cnt    <= n_free_cnt;
            r_fresh       <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type  <= t_req_type'(i_req_type);
            r_req_bytes <= i_request_bytes;
            r_req_idx   <= i_freed_index;
        end
        if (i_cmd.commit) begin
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
            r_out_addr   <= n_out_addr;
            r_out_free   <= POOL_W'(n_free_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_status        = r_out_status;
    assign o_given_index   = r_out_index;
    assign o_given_address = r_out_addr;
    assign o_blocks_free   = r_out_free;

endmodule

// ----- sv/fixed_block_pool_allocator_core.sv -----
// Top level of the fixed block pool allocator: controller plus datapath.
//
//  Channel   Direction  Handshake          Payload
//  i_req     in         valid / ready      req_type, request_bytes, freed_index
//  o_rsp     out        valid / ready      status, given_index, given_address,
//                                          blocks_free
//  i_cfg_*   in         write enable only  i_cfg_index, i_cfg_data
//
//  In each request transaction, acceptance in ST_IDLE launches the read of
//  the head's (or the freed block's) link word; then ST_EXEC, once the
//  response register can take a result, updates the list and loads that
//  register from the registered read data. After reset the pool is ready at
//  once; no memory clearing pass is needed, because a count of never-allocated
//  blocks stands in for the initial chain. A response waiting in the output
//  register stalls only the ST_EXEC step of the next transaction, not acceptance.
module fixed_block_pool_allocator_core #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fbpa_req_if.sink                        i_req,
    fbpa_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fbpa_pkg::*;

    t_ctrl_cmd cmd;

    // The controller decides when a request is taken and when its result is
    // written to the response register; it never looks at the payload.
    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the link memory, the head, the free count and the
    // configuration, and computes the allocated address with one multiply-add.
    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req.req_type),
        .i_request_bytes (i_req.request_bytes),
        .i_freed_index   (i_req.freed_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_rsp.status),
        .o_given_index   (o_rsp.given_index),
        .o_given_address (o_rsp.given_address),
        .o_blocks_free   (o_rsp.blocks_free)
    );

endmodule

// ----- sv/fbpa_checker.sv -----
// Port-level checks of the allocator, bound to the top level.
module fbpa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [fbpa_pkg::STATUS_W-1:0]  i_status,
    input logic [fbpa_pkg::IDX_OUT_W-1:0] i_given_index,
    input logic [fbpa_pkg::ADDR_BITS-1:0] i_given_address,
    input logic [fbpa_pkg::POOL_W-1:0]    i_blocks_free
);
    import fbpa_pkg::*;

    // A waiting response keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rsp_ready === 1'bx || !i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_given_index) && $stable(i_given_address)
            && $stable(i_blocks_free))
        else $error("response changed while stalled");

    // Requests are never accepted back to back.
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted in back-to-back cycles");

    // A fresh response is always preceded by an accepted request transaction.
    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("response without a preceding request");

    // A failed request gives no block.
    a_no_block_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != STAT_OK |-> i_given_index == '0
            && i_given_address == '0)
        else $error("block reported on a failed request");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_given_index   (o_rsp.given_index),
    .i_given_address (o_rsp.given_address),
    .i_blocks_free   (o_rsp.blocks_free)
);

// ----- verif/tb_fixed_block_pool_allocator_core.sv -----
// Self-checking testbench of the fixed block pool allocator core.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_core;
    import fbpa_pkg::*;

    localparam int unsigned POOL_MAX        = DEF_MAX_BLOCKS;
    localparam int unsigned RANDOM_ITEMS    = 1930;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = RANDOM_ITEMS / RANDOM_PHASES;
    // During this phase neither side idles, so back-to-back traffic is covered.
    localparam int unsigned CALM_PHASE      = 3;
    localparam int unsigned IDLE_PERCENT    = 28;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Register index with no register behind it; a write there must not rebuild the pool.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] index;
        logic [ADDR_BITS-1:0] address;
        logic [POOL_W-1:0]    free_blocks;
    } t_alloc_resp;

    localparam t_alloc_resp NO_ANSWER = '0;

    typedef enum logic {
        ROW_REQUEST   = 1'b0,
        ROW_REG_WRITE = 1'b1
    } t_row_kind;

    // One row of the directed table: either a register write or a request. A request
    // row with fixed_answer set carries its expected response; otherwise the pool
    // model below supplies it.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        t_req_type             req;
        logic [BYTES_W-1:0]    nbytes;
        logic [IDX_OUT_W-1:0]  block;
        logic                  fixed_answer;
        t_alloc_resp           answer;
    } t_dir_row;

    localparam int unsigned N_DIR_ROWS = 29;

    // The table starts from the reset settings: 64-byte blocks, 256 blocks, base 0.
    localparam t_dir_row DIR_ROWS [N_DIR_ROWS] = '{
        // Fresh pool: the highest block comes out first, a request of exactly one
        // block fits, one byte more and the all-ones size are refused.
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_OK, 8'd255, 32'd16320, 9'd255}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd64, 8'd0, 1'b1,
          '{STAT_OK, 8'd254, 32'd16256, 9'd254}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd65, 8'd0, 1'b1,
          '{STAT_TOO_LARGE, 8'd0, 32'd0, 9'd254}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'h1FFFF, 8'd0, 1'b1,
          '{STAT_TOO_LARGE, 8'd0, 32'd0, 9'd254}},
        // Free, then a second free of the same block and a free of a block that
        // was never handed out.
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'h1FFFF, 8'd254, 1'b1,
          '{STAT_OK, 8'd0, 32'd0, 9'd255}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'd254, 1'b1,
          '{STAT_BAD_INDEX, 8'd0, 32'd0, 9'd255}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'd0, 1'b1,
          '{STAT_BAD_INDEX, 8'd0, 32'd0, 9'd255}},
        // The block just freed must be the next one given out.
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd1, 8'hFF, 1'b0, NO_ANSWER},
        // Two-block pool: drain it, then hit the empty and too-large cases.
        '{ROW_REG_WRITE, CFG_POOL_BLOCKS, 32'd2, REQ_ALLOC, 17'd0, 8'd0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_OK, 8'd1, 32'd64, 9'd1}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_OK, 8'd0, 32'd0, 9'd0}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_EMPTY, 8'd0, 32'd0, 9'd0}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd65, 8'd0, 1'b1,
          '{STAT_TOO_LARGE, 8'd0, 32'd0, 9'd0}},
        // Frees of indexes outside the pool are rejected; a held block inside it is freed.
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'd2, 1'b1,
          '{STAT_BAD_INDEX, 8'd0, 32'd0, 9'd0}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'hFF, 1'b1,
          '{STAT_BAD_INDEX, 8'd0, 32'd0, 9'd0}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'd1, 1'b1,
          '{STAT_OK, 8'd0, 32'd0, 9'd1}},
        // A pool size of zero behaves as a single block.
        '{ROW_REG_WRITE, CFG_POOL_BLOCKS, 32'd0, REQ_ALLOC, 17'd0, 8'd0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_OK, 8'd0, 32'd0, 9'd0}},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_EMPTY, 8'd0, 32'd0, 9'd0}},
        // Zero block size serves only zero-byte requests.
        '{ROW_REG_WRITE, CFG_BLOCK_BYTES, 32'd0, REQ_ALLOC, 17'd0, 8'd0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd1, 8'd0, 1'b1,
          '{STAT_TOO_LARGE, 8'd0, 32'd0, 9'd1}},
        // An oversized pool setting is clamped to the full block memory.
        '{ROW_REG_WRITE, CFG_POOL_BLOCKS, 32'hFFFFFFFF, REQ_ALLOC, 17'd0, 8'd0, 1'b0,
          NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b1,
          '{STAT_OK, 8'd255, 32'd0, 9'd255}},
        // Top base with the largest block size makes the address wrap.
        '{ROW_REG_WRITE, CFG_POOL_BASE, 32'hFFFFFFFF, REQ_ALLOC, 17'd0, 8'd0, 1'b0,
          NO_ANSWER},
        '{ROW_REG_WRITE, CFG_BLOCK_BYTES, 32'h0001FFFF, REQ_ALLOC, 17'd0, 8'd0, 1'b0,
          NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'h1FFFF, 8'd0, 1'b0, NO_ANSWER},
        // A write to the unmapped index leaves the allocated block allocated.
        '{ROW_REG_WRITE, CFG_UNMAPPED, 32'd1, REQ_ALLOC, 17'd0, 8'd0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_ALLOC, 17'd0, 8'd0, 1'b0, NO_ANSWER},
        '{ROW_REQUEST, CFG_BLOCK_BYTES, 32'h0, REQ_FREE, 17'd0, 8'd255, 1'b0, NO_ANSWER}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fbpa_req_if req_bus ();
    fbpa_rsp_if rsp_bus ();

    fixed_block_pool_allocator_core #(
        .MAX_BLOCKS (POOL_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pool model. It holds its own copy of the registers, the link memory,
    // the head pointer, the free count and one allocated flag per block.
    // Only the stimulus process calls it, at the edge where a transaction
    // or a register write takes effect.
    // ------------------------------------------------------------------
    logic [POOL_W-1:0]    link_of [POOL_MAX];
    logic                 in_use  [POOL_MAX];
    logic [POOL_W-1:0]    head_block;
    logic [POOL_W-1:0]    free_count;
    logic [BYTES_W-1:0]   blk_bytes;
    logic [POOL_W-1:0]    pool_setting;
    logic [ADDR_BITS-1:0] base_addr;

    // A pool size of zero counts as one block, anything above the memory as all of it.
    function automatic int unsigned pool_size();
        int unsigned n;
        n = pool_setting;
        if (n < 1) begin
            n = 1;
        end
        if (n > POOL_MAX) begin
            n = POOL_MAX;
        end
        return n;
    endfunction

    // Every block becomes free, chained so that the highest index pops first.
    function automatic void rebuild_free_list();
        int unsigned n;
        n = pool_size();
        for (int b = 0; b < POOL_MAX; b++) begin
            link_of[b] = (b > 0 && b < n) ? POOL_W'(b - 1) : '0;
            in_use[b]  = 1'b0;
        end
        head_block = POOL_W'(n - 1);
        free_count = POOL_W'(n);
    endfunction

    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] index,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_BLOCK_BYTES: begin
                blk_bytes = data[BYTES_W-1:0];
            end
            CFG_POOL_BLOCKS: begin
                pool_setting = data[POOL_W-1:0];
            end
            CFG_POOL_BASE: begin
                base_addr = data[ADDR_BITS-1:0];
            end
            default: begin
                return;
            end
        endcase
        rebuild_free_list();
    endfunction

    // Applies one request to the model and returns the response it must produce.
    function automatic t_alloc_resp serve_request(input t_req_type req,
                                                  input logic [BYTES_W-1:0] nbytes,
                                                  input logic [IDX_OUT_W-1:0] block);
        t_alloc_resp resp;
        int unsigned top;
        resp = NO_ANSWER;
        resp.status = STAT_OK;
        if (req == REQ_ALLOC) begin
            // The size test wins over the empty test.
            if (nbytes > blk_bytes) begin
                resp.status = STAT_TOO_LARGE;
            end else if (free_count == '0) begin
                resp.status = STAT_EMPTY;
            end else begin
                top = head_block % POOL_MAX;
                in_use[top]  = 1'b1;
                head_block   = link_of[top];
                free_count   = free_count - 1'b1;
                resp.index   = IDX_OUT_W'(top);
                resp.address = base_addr + ADDR_BITS'(top * blk_bytes);
            end
        end else begin
            // Out-of-pool indexes and blocks that are already free are both rejected.
            if (32'(block) >= pool_size() || !in_use[block]) begin
                resp.status = STAT_BAD_INDEX;
            end else begin
                in_use[block]  = 1'b0;
                link_of[block] = head_block;
                head_block     = POOL_W'(block);
                free_count     = free_count + 1'b1;
            end
        end
        resp.free_blocks = free_count;
        return resp;
    endfunction

    // ------------------------------------------------------------------
    // Expected responses and bookkeeping.
    // ------------------------------------------------------------------
    t_alloc_resp pending_resp [$];
    t_alloc_resp oldest_resp;
    int unsigned issued       = 0;   // requests accepted, owned by the stimulus process
    int unsigned answered     = 0;   // responses taken, advanced nonblocking by the checker
    int unsigned mismatches   = 0;
    int unsigned reg_writes   = 0;
    int unsigned status_seen [4];
    logic        calm_stretch = 1'b0;

    // Sends one request transaction after a random gap and updates the model at
    // the edge where it is accepted. Valid stays high on return, so a following
    // request can follow without a bubble.
    task automatic send_request(input t_req_type req, input logic [BYTES_W-1:0] nbytes,
                                input logic [IDX_OUT_W-1:0] block,
                                input logic fixed_answer, input t_alloc_resp answer);
        int unsigned gap;
        t_alloc_resp predicted;
        gap = 0;
        while (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            gap++;
        end
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= req;
        req_bus.request_bytes <= nbytes;
        req_bus.freed_index   <= block;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        predicted = serve_request(req, nbytes, block);
        pending_resp.push_back(fixed_answer ? answer : predicted);
        status_seen[predicted.status]++;
        issued++;
    endtask

    // Register writes happen only once every response is back, so the block is idle.
    // The write enable is left high on return; the next request lowers it, which lets
    // writes follow each other without two assignments to it in one step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        req_bus.valid <= 1'b0;
        while (answered != issued) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_register_write(index, data);
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, except during the calm phase.
    // ------------------------------------------------------------------
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic void check_field(input string name, input logic [ADDR_BITS-1:0] want,
                                        input logic [ADDR_BITS-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        end
    endfunction

    // Each response transaction is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: response with nothing outstanding, status %0d index %0d",
                             $time, rsp_bus.status, rsp_bus.given_index);
                end
            end else begin
                oldest_resp = pending_resp.pop_front();
                check_field("status", ADDR_BITS'(oldest_resp.status),
                            ADDR_BITS'(rsp_bus.status));
                check_field("given_index", ADDR_BITS'(oldest_resp.index),
                            ADDR_BITS'(rsp_bus.given_index));
                check_field("given_address", oldest_resp.address, rsp_bus.given_address);
                check_field("blocks_free", ADDR_BITS'(oldest_resp.free_blocks),
                            ADDR_BITS'(rsp_bus.blocks_free));
                answered <= answered + 1;
            end
        end
    end

    // The run is declared hung once the quiet counter, cleared by any transaction,
    // register write or reset, reaches STALL_LIMIT.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
                i_cfg_we === 1'b1 || i_rst_n !== 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                 $time, STALL_LIMIT, pending_resp.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random phases.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row              row;
        t_req_type             req;
        logic [BYTES_W-1:0]    nbytes;
        logic [IDX_OUT_W-1:0]  block;
        logic [CFG_DATA_W-1:0] value;
        int unsigned           bias;
        int unsigned           held;
        int unsigned           skip;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_index           <= CFG_BLOCK_BYTES;
        i_cfg_data            <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_ALLOC;
        req_bus.request_bytes <= '0;
        req_bus.freed_index   <= '0;
        status_seen           = '{default: 0};

        blk_bytes    = BLOCK_BYTES_RST;
        pool_setting = POOL_BLOCKS_RST;
        base_addr    = POOL_BASE_RST;
        rebuild_free_list();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR_ROWS; r++) begin
            row = DIR_ROWS[r];
            if (row.kind == ROW_REG_WRITE) begin
                write_register(row.reg_index, row.reg_data);
            end else begin
                send_request(row.req, row.nbytes, row.block, row.fixed_answer, row.answer);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm_stretch <= (phase == CALM_PHASE);

            // Block size: zero, one, the reset size, all ones, or something in between.
            // Bits above the register are sometimes set to check that they are dropped.
            case ($urandom_range(5))
                0: value = 32'd0;
                1: value = 32'd1;
                2: value = 32'd64;
                3: value = 32'h0001FFFF;
                default: value = $urandom_range(5000, 2);
            endcase
            if ($urandom_range(3) == 0) begin
                value = value | ($urandom() & 32'hFFFE0000);
            end
            write_register(CFG_BLOCK_BYTES, value);

            // Mostly small pools, so that the pool runs empty and refills often.
            case ($urandom_range(7))
                0: value = $urandom_range(1);
                1: value = 32'd2;
                2, 3, 4: value = $urandom_range(16, 3);
                5: value = $urandom_range(64, 17);
                6: value = 32'd256;
                default: value = $urandom_range(511, 257);
            endcase
            if ($urandom_range(3) == 0) begin
                value = value | ($urandom() & 32'hFFFFFE00);
            end
            write_register(CFG_POOL_BLOCKS, value);

            case ($urandom_range(3))
                0: value = 32'd0;
                1: value = 32'hFFFFFFFF;
                default: value = $urandom();
            endcase
            write_register(CFG_POOL_BASE, value);

            // Per phase, a different leaning between allocations and frees.
            bias = $urandom_range(80, 35);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through, sometimes poke the unmapped index while blocks are held.
                if (n == ITEMS_PER_PHASE / 2 && $urandom_range(1) == 1) begin
                    write_register(CFG_UNMAPPED, $urandom());
                end
                held   = pool_size() - free_count;
                nbytes = BYTES_W'($urandom());
                block  = IDX_OUT_W'($urandom());
                if ($urandom_range(99) < 80) begin
                    // Well-formed traffic: allocations that fit and frees of held blocks.
                    // On an empty pool most requests are frees, the rest hit the empty case.
                    if (held != 0 &&
                        $urandom_range(99) >= (free_count == '0 ? 30 : bias)) begin
                        req  = REQ_FREE;
                        skip = $urandom_range(held - 1);
                        for (int b = 0; b < POOL_MAX; b++) begin
                            if (in_use[b]) begin
                                if (skip == 0) begin
                                    block = IDX_OUT_W'(b);
                                    break;
                                end
                                skip--;
                            end
                        end
                    end else begin
                        req    = REQ_ALLOC;
                        nbytes = BYTES_W'($urandom_range(blk_bytes));
                    end
                end else begin
                    // Noise: random sizes, and frees of random or unheld blocks.
                    req = t_req_type'($urandom_range(1));
                    if ($urandom_range(1) == 1) begin
                        block = IDX_OUT_W'($urandom_range(pool_size() - 1));
                    end
                end
                send_request(req, nbytes, block, 1'b0, NO_ANSWER);
            end
        end

        req_bus.valid <= 1'b0;
        calm_stretch  <= 1'b0;
        while (answered != issued) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests with %0d register writes over %0d random pool setups.",
                 issued, reg_writes, RANDOM_PHASES);
        $display("Outcomes: %0d served, %0d empty, %0d too large, %0d rejected frees.",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_TOO_LARGE], status_seen[STAT_BAD_INDEX]);
        if (mismatches == 0 && pending_resp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fbpa_pkg.sv
sv/fbpa_ifs.sv
sv/fbpa_ctrl.sv
sv/fbpa_datapath.sv
sv/fixed_block_pool_allocator_core.sv
sv/fbpa_checker.sv
verif/tb_fixed_block_pool_allocator_core.sv
